/* hdl/ffra_pkg.sv */
// shared codes and types of the first-fit region allocator
package ffra_pkg;

   localparam logic [1:0] KIND_ALLOC  = 2'd0;
   localparam logic [1:0] KIND_FREE   = 2'd1;
   localparam logic [1:0] KIND_REINIT = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_FIT    = 3'd1;
   localparam logic [2:0] ST_NO_DESC   = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_ZERO_ARG  = 3'd4;

   localparam logic CSR_BASE   = 1'b0;
   localparam logic CSR_LENGTH = 1'b1;

   localparam logic [31:0] RESET_BASE   = 32'h0010_0000;
   localparam logic [31:0] RESET_LENGTH = 32'h0010_0000;

   typedef struct packed {
      logic wr_start;
      logic wr_stop;
      logic wr_link;
   } mem_wen_type;

endpackage

/* hdl/ffra_mem.sv */
// descriptor memory: start, end and link fields, one write and one read port
module ffra_mem #(
   parameter int MAX_RANGES = 64,
   parameter int ADDR_BITS  = 32,
   localparam int AW = $clog2(MAX_RANGES),
   localparam int IW = $clog2(MAX_RANGES + 1)
) (
   input  logic                 clock,
   input  ffra_pkg::mem_wen_type wen,
   input  logic [AW-1:0]        waddr,
   input  logic [ADDR_BITS-1:0] wstart,
   input  logic [ADDR_BITS-1:0] wstop,
   input  logic [IW-1:0]        wlink,
   input  logic [AW-1:0]        raddr,
   output logic [ADDR_BITS-1:0] rd_start,
   output logic [ADDR_BITS-1:0] rd_stop,
   output logic [IW-1:0]        rd_link
);
   logic [ADDR_BITS-1:0] start_mem [MAX_RANGES];
   logic [ADDR_BITS-1:0] stop_mem  [MAX_RANGES];
   logic [IW-1:0]        link_mem  [MAX_RANGES];
   logic [ADDR_BITS-1:0] rd_start_ff;
   logic [ADDR_BITS-1:0] rd_stop_ff;
   logic [IW-1:0]        rd_link_ff;

   always_ff @(posedge clock) begin
      if (wen.wr_start) begin
         start_mem[waddr] <= wstart;
      end
      if (wen.wr_stop) begin
         stop_mem[waddr] <= wstop;
      end
      if (wen.wr_link) begin
         link_mem[waddr] <= wlink;
      end
   end

   always_ff @(posedge clock) begin
      rd_start_ff <= start_mem[raddr];
      rd_stop_ff  <= stop_mem[raddr];
      rd_link_ff  <= link_mem[raddr];
   end

   assign rd_start = rd_start_ff;
   assign rd_stop  = rd_stop_ff;
   assign rd_link  = rd_link_ff;
endmodule

/* hdl/ffra_ctrl.sv */
// list walking sequencer of the allocator, list heads and result register
module ffra_ctrl #(
   parameter int MAX_RANGES = 64,
   parameter int ADDR_BITS  = 32,
   localparam int AW = $clog2(MAX_RANGES),
   localparam int IW = $clog2(MAX_RANGES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_kind,
   input  logic [31:0]           req_request_bytes,
   input  logic [31:0]           req_block_address,
   input  logic [31:0]           cfg_base,
   input  logic [31:0]           cfg_length,
   output ffra_pkg::mem_wen_type wen,
   output logic [AW-1:0]         waddr,
   output logic [ADDR_BITS-1:0]  wstart,
   output logic [ADDR_BITS-1:0]  wstop,
   output logic [IW-1:0]         wlink,
   output logic [AW-1:0]         raddr,
   input  logic [ADDR_BITS-1:0]  rd_start,
   input  logic [ADDR_BITS-1:0]  rd_stop,
   input  logic [IW-1:0]         rd_link,
   output logic                  rsp_valid,
   output logic [2:0]            rsp_status,
   output logic [31:0]           rsp_granted_address,
   output logic [31:0]           rsp_granted_length,
   output logic [1:0]            rsp_merges_done
);
   import ffra_pkg::*;

   localparam int DW = (ADDR_BITS > 32 ? ADDR_BITS : 32) + 1;
   localparam logic [IW-1:0] NIL = IW'(MAX_RANGES);

   localparam logic [3:0] S_INIT    = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_A_SCAN  = 4'd2;
   localparam logic [3:0] S_A_POP   = 4'd3;
   localparam logic [3:0] S_A_WREPL = 4'd4;
   localparam logic [3:0] S_A_WPREV = 4'd5;
   localparam logic [3:0] S_A_WLINK = 4'd6;
   localparam logic [3:0] S_A_WCUR  = 4'd7;
   localparam logic [3:0] S_WALK    = 4'd8;
   localparam logic [3:0] S_F_CHK   = 4'd9;
   localparam logic [3:0] S_F_W1    = 4'd10;
   localparam logic [3:0] S_F_W2    = 4'd11;
   localparam logic [3:0] S_F_W3    = 4'd12;
   localparam logic [3:0] S_F_W4    = 4'd13;

   logic [3:0]           state_ff, state_in, ret_ff, ret_in;
   logic [IW-1:0]        free_head_ff, free_head_in, used_head_ff, used_head_in;
   logic [IW-1:0]        spare_ff, spare_in, fresh_ff, fresh_in;
   logic [IW-1:0]        cur_ff, cur_in, prev_ff, prev_in, repl_ff, repl_in, cl_ff, cl_in;
   logic [IW-1:0]        wk_p_ff, wk_p_in, wk_c_ff, wk_c_in, nl_ff, nl_in;
   logic [ADDR_BITS-1:0] cs_ff, cs_in, ce_ff, ce_in, wk_pe_ff, wk_pe_in;
   logic [ADDR_BITS-1:0] ns_ff, ns_in, ne_ff, ne_in;
   logic [DW-1:0]        key_ff, key_in;
   logic [31:0]          op_bytes_ff, op_bytes_in;
   logic                 split_ff, split_in, ml_ff, ml_in, mr_ff, mr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_status_ff, rsp_status_in;
   logic [31:0]          rsp_addr_ff, rsp_addr_in, rsp_len_ff, rsp_len_in;
   logic [1:0]           rsp_merges_ff, rsp_merges_in;

   logic                 fin;
   logic [2:0]           fin_status;
   logic [31:0]          fin_addr, fin_len;
   logic [1:0]           fin_merges;
   logic                 ws;
   logic [IW-1:0]        ws_head;
   logic [DW-1:0]        ws_key;
   logic [3:0]           ws_ret;
   logic                 do_reinit;

   logic [ADDR_BITS-1:0] base_a, end_r;
   logic [DW-1:0]        sum_r, len_r, need, size;
   logic                 zero_len, ml, mr;

   assign base_a   = ADDR_BITS'(cfg_base);
   assign zero_len = (cfg_length == 32'd0);
   assign sum_r    = DW'(base_a) + DW'(cfg_length) - DW'(1);
   assign end_r    = (sum_r > DW'({ADDR_BITS{1'b1}})) ? '1 : sum_r[ADDR_BITS-1:0];
   assign len_r    = DW'(end_r) - DW'(base_a) + DW'(1);
   assign need     = DW'(op_bytes_ff) - DW'(1);
   assign size     = DW'(rd_stop - rd_start);
   assign ml       = (wk_p_ff != NIL) && (DW'(wk_pe_ff) + DW'(1) == DW'(cs_ff));
   assign mr       = (wk_c_ff != NIL) && (DW'(ce_ff) + DW'(1) == DW'(ns_ff));

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      free_head_in = free_head_ff;
      used_head_in = used_head_ff;
      spare_in = spare_ff;
      fresh_in = fresh_ff;
      cur_in = cur_ff;
      prev_in = prev_ff;
      repl_in = repl_ff;
      cl_in = cl_ff;
      wk_p_in = wk_p_ff;
      wk_c_in = wk_c_ff;
      wk_pe_in = wk_pe_ff;
      nl_in = nl_ff;
      ns_in = ns_ff;
      ne_in = ne_ff;
      cs_in = cs_ff;
      ce_in = ce_ff;
      key_in = key_ff;
      op_bytes_in = op_bytes_ff;
      split_in = split_ff;
      ml_in = ml_ff;
      mr_in = mr_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in = rsp_addr_ff;
      rsp_len_in = rsp_len_ff;
      rsp_merges_in = rsp_merges_ff;
      wen = '0;
      waddr = cur_ff[AW-1:0];
      wstart = cs_ff;
      wstop = ce_ff;
      wlink = NIL;
      raddr = '0;
      fin = 1'b0;
      fin_status = ST_OK;
      fin_addr = '0;
      fin_len = '0;
      fin_merges = '0;
      ws = 1'b0;
      ws_head = NIL;
      ws_key = '0;
      ws_ret = S_IDLE;
      do_reinit = 1'b0;

      unique case (state_ff)
         S_INIT: begin
            do_reinit = 1'b1;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               unique case (req_kind)
                  KIND_ALLOC: begin
                     op_bytes_in = req_request_bytes;
                     if (req_request_bytes == 32'd0) begin
                        fin = 1'b1;
                        fin_status = ST_ZERO_ARG;
                     end else if (free_head_ff == NIL) begin
                        fin = 1'b1;
                        fin_status = ST_NO_FIT;
                     end else begin
                        raddr = free_head_ff[AW-1:0];
                        cur_in = free_head_ff;
                        prev_in = NIL;
                        state_in = S_A_SCAN;
                     end
                  end
                  KIND_FREE: begin
                     if (req_block_address == 32'd0) begin
                        fin = 1'b1;
                        fin_status = ST_ZERO_ARG;
                     end else begin
                        ws = 1'b1;
                        ws_head = used_head_ff;
                        ws_key = DW'(req_block_address);
                        ws_ret = S_F_CHK;
                     end
                  end
                  KIND_REINIT: begin
                     do_reinit = 1'b1;
                     fin = 1'b1;
                     fin_addr = zero_len ? 32'd0 : 32'(base_a);
                     fin_len = zero_len ? 32'd0 : 32'(len_r);
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_A_SCAN: begin
            if (need > size) begin
               if (rd_link == NIL) begin
                  fin = 1'b1;
                  fin_status = ST_NO_FIT;
               end else begin
                  prev_in = cur_ff;
                  cur_in = rd_link;
                  raddr = rd_link[AW-1:0];
               end
            end else begin
               cs_in = rd_start;
               ce_in = rd_stop;
               cl_in = rd_link;
               split_in = (need < size);
               if (need < size) begin
                  if (spare_ff == NIL) begin
                     fin = 1'b1;
                     fin_status = ST_NO_DESC;
                  end else if (spare_ff == fresh_ff) begin
                     repl_in = spare_ff;
                     spare_in = spare_ff + IW'(1);
                     fresh_in = fresh_ff + IW'(1);
                     state_in = S_A_WREPL;
                  end else begin
                     raddr = spare_ff[AW-1:0];
                     state_in = S_A_POP;
                  end
               end else begin
                  repl_in = rd_link;
                  state_in = S_A_WPREV;
               end
            end
         end
         S_A_POP: begin
            repl_in = spare_ff;
            spare_in = rd_link;
            state_in = S_A_WREPL;
         end
         S_A_WREPL: begin
            wen = '{wr_start: 1'b1, wr_stop: 1'b1, wr_link: 1'b1};
            waddr = repl_ff[AW-1:0];
            wstart = ADDR_BITS'(DW'(cs_ff) + DW'(op_bytes_ff));
            wstop = ce_ff;
            wlink = cl_ff;
            state_in = S_A_WPREV;
         end
         S_A_WPREV: begin
            if (prev_ff != NIL) begin
               wen.wr_link = 1'b1;
               waddr = prev_ff[AW-1:0];
               wlink = repl_ff;
            end else begin
               free_head_in = repl_ff;
            end
            ws = 1'b1;
            ws_head = used_head_ff;
            ws_key = DW'(cs_ff);
            ws_ret = S_A_WLINK;
         end
         S_WALK: begin
            if (DW'(rd_start) < key_ff) begin
               wk_p_in = wk_c_ff;
               wk_pe_in = rd_stop;
               wk_c_in = rd_link;
               if (rd_link == NIL) begin
                  state_in = ret_ff;
               end else begin
                  raddr = rd_link[AW-1:0];
               end
            end else begin
               ns_in = rd_start;
               ne_in = rd_stop;
               nl_in = rd_link;
               state_in = ret_ff;
            end
         end
         S_A_WLINK: begin
            if (wk_p_ff != NIL) begin
               wen.wr_link = 1'b1;
               waddr = wk_p_ff[AW-1:0];
               wlink = cur_ff;
            end else begin
               used_head_in = cur_ff;
            end
            state_in = S_A_WCUR;
         end
         S_A_WCUR: begin
            wen.wr_link = 1'b1;
            wen.wr_stop = split_ff;
            waddr = cur_ff[AW-1:0];
            wlink = wk_c_ff;
            wstop = ADDR_BITS'(DW'(cs_ff) + DW'(op_bytes_ff) - DW'(1));
            fin = 1'b1;
            fin_addr = 32'(cs_ff);
            fin_len = op_bytes_ff;
         end
         S_F_CHK: begin
            if (wk_c_ff == NIL || DW'(ns_ff) != key_ff) begin
               fin = 1'b1;
               fin_status = ST_NOT_FOUND;
            end else begin
               cur_in = wk_c_ff;
               cs_in = ns_ff;
               ce_in = ne_ff;
               if (wk_p_ff != NIL) begin
                  wen.wr_link = 1'b1;
                  waddr = wk_p_ff[AW-1:0];
                  wlink = nl_ff;
               end else begin
                  used_head_in = nl_ff;
               end
               ws = 1'b1;
               ws_head = free_head_ff;
               ws_key = DW'(ns_ff);
               ws_ret = S_F_W1;
            end
         end
         S_F_W1: begin
            ml_in = ml;
            mr_in = mr;
            if (!ml) begin
               if (wk_p_ff != NIL) begin
                  wen.wr_link = 1'b1;
                  waddr = wk_p_ff[AW-1:0];
                  wlink = cur_ff;
               end else begin
                  free_head_in = cur_ff;
               end
            end
            state_in = S_F_W2;
         end
         S_F_W2: begin
            wen.wr_stop = 1'b1;
            wen.wr_link = 1'b1;
            waddr = ml_ff ? wk_p_ff[AW-1:0] : cur_ff[AW-1:0];
            wstop = mr_ff ? ne_ff : ce_ff;
            wlink = mr_ff ? nl_ff : wk_c_ff;
            state_in = S_F_W3;
         end
         S_F_W3: begin
            if (ml_ff) begin
               wen.wr_link = 1'b1;
               waddr = cur_ff[AW-1:0];
               wlink = spare_ff;
               spare_in = cur_ff;
            end
            state_in = S_F_W4;
         end
         S_F_W4: begin
            if (mr_ff) begin
               wen.wr_link = 1'b1;
               waddr = wk_c_ff[AW-1:0];
               wlink = spare_ff;
               spare_in = wk_c_ff;
            end
            fin = 1'b1;
            fin_addr = 32'(cs_ff);
            fin_len = 32'(DW'(ce_ff) - DW'(cs_ff) + DW'(1));
            fin_merges = {1'b0, ml_ff} + {1'b0, mr_ff};
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // region reload
      if (do_reinit) begin
         used_head_in = NIL;
         if (zero_len) begin
            free_head_in = NIL;
            spare_in = '0;
            fresh_in = '0;
         end else begin
            wen = '{wr_start: 1'b1, wr_stop: 1'b1, wr_link: 1'b1};
            waddr = '0;
            wstart = base_a;
            wstop = end_r;
            wlink = NIL;
            free_head_in = '0;
            spare_in = IW'(1);
            fresh_in = IW'(1);
         end
      end

      // list walk launch
      if (ws) begin
         wk_p_in = NIL;
         wk_c_in = ws_head;
         key_in = ws_key;
         ret_in = ws_ret;
         raddr = ws_head[AW-1:0];
         state_in = (ws_head == NIL) ? ws_ret : S_WALK;
      end

      if (fin) begin
         state_in = S_IDLE;
         rsp_valid_in = 1'b1;
         rsp_status_in = fin_status;
         rsp_addr_in = fin_addr;
         rsp_len_in = fin_len;
         rsp_merges_in = fin_merges;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         rsp_valid_ff <= 1'b0;
         free_head_ff <= '0;
         used_head_ff <= NIL;
         spare_ff <= IW'(1);
         fresh_ff <= IW'(1);
         ret_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         free_head_ff <= free_head_in;
         used_head_ff <= used_head_in;
         spare_ff <= spare_in;
         fresh_ff <= fresh_in;
         ret_ff <= ret_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      prev_ff <= prev_in;
      repl_ff <= repl_in;
      cl_ff <= cl_in;
      wk_p_ff <= wk_p_in;
      wk_c_ff <= wk_c_in;
      wk_pe_ff <= wk_pe_in;
      nl_ff <= nl_in;
      ns_ff <= ns_in;
      ne_ff <= ne_in;
      cs_ff <= cs_in;
      ce_ff <= ce_in;
      key_ff <= key_in;
      op_bytes_ff <= op_bytes_in;
      split_ff <= split_in;
      ml_ff <= ml_in;
      mr_ff <= mr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_len_ff <= rsp_len_in;
      rsp_merges_ff <= rsp_merges_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_granted_length = rsp_len_ff;
   assign rsp_merges_done = rsp_merges_ff;
endmodule

/* hdl/first_fit_region_allocator_unit.sv */
// top level of the first-fit region allocator: csr registers, sequencer, descriptor memory
//
//   channel  ports                                     handshake
//   request  req_kind, req_request_bytes,              start high while busy low
//            req_block_address
//   result   rsp_status, rsp_granted_address,          rsp_valid, one cycle, no stall
//            rsp_granted_length, rsp_merges_done
//   csr      csr_index, csr_wdata                      csr_we, taken at once
//
// a reinitialize word, a zero argument or an empty free list finishes in the idle state;
// other allocate and free words run through the sequencer states, one descriptor read
// per cycle on the memory read port while walking the free and used lists.
// the result appears on the cycle after the word finishes.
// after reset the unit is busy in its init state while it loads the region descriptor.
// results cannot be stalled; start is ignored while busy.
module first_fit_region_allocator_unit #(
   parameter int MAX_RANGES = 64,
   parameter int ADDR_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_request_bytes,
   input  logic [31:0] req_block_address,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_granted_address,
   output logic [31:0] rsp_granted_length,
   output logic [1:0]  rsp_merges_done,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   import ffra_pkg::*;

   localparam int AW = $clog2(MAX_RANGES);
   localparam int IW = $clog2(MAX_RANGES + 1);

   logic [31:0]          base_ff, base_in, length_ff, length_in;
   mem_wen_type          wen;
   logic [AW-1:0]        waddr, raddr;
   logic [ADDR_BITS-1:0] wstart, wstop, rd_start, rd_stop;
   logic [IW-1:0]        wlink, rd_link;

   always_comb begin
      base_in = base_ff;
      length_in = length_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BASE:   base_in = csr_wdata;
            CSR_LENGTH: length_in = csr_wdata;
            default:    base_in = base_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= RESET_BASE;
         length_ff <= RESET_LENGTH;
      end else begin
         base_ff <= base_in;
         length_ff <= length_in;
      end
   end

   ffra_ctrl #(.MAX_RANGES(MAX_RANGES), .ADDR_BITS(ADDR_BITS)) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_request_bytes(req_request_bytes),
      .req_block_address(req_block_address),
      .cfg_base(base_ff),
      .cfg_length(length_ff),
      .wen(wen),
      .waddr(waddr),
      .wstart(wstart),
      .wstop(wstop),
      .wlink(wlink),
      .raddr(raddr),
      .rd_start(rd_start),
      .rd_stop(rd_stop),
      .rd_link(rd_link),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_granted_address(rsp_granted_address),
      .rsp_granted_length(rsp_granted_length),
      .rsp_merges_done(rsp_merges_done)
   );

   ffra_mem #(.MAX_RANGES(MAX_RANGES), .ADDR_BITS(ADDR_BITS)) u_mem (
      .clock(clock),
      .wen(wen),
      .waddr(waddr),
      .wstart(wstart),
      .wstop(wstop),
      .wlink(wlink),
      .raddr(raddr),
      .rd_start(rd_start),
      .rd_stop(rd_stop),
      .rd_link(rd_link)
   );
endmodule

/* hdl/ffra_checker.sv */
// port-level checks of the allocator and their binding to the top level
module ffra_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_kind,
   input logic [31:0] req_request_bytes,
   input logic        rsp_valid,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_granted_address,
   input logic [31:0] rsp_granted_length,
   input logic [1:0]  rsp_merges_done
);
   import ffra_pkg::*;

   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start)))
      else $error("result word without a request in progress");

   a_zero_alloc: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == KIND_ALLOC && req_request_bytes == 32'd0)
      |=> (rsp_valid && rsp_status == ST_ZERO_ARG))
      else $error("zero size allocate not rejected at once");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
      (rsp_granted_address == 32'd0 && rsp_granted_length == 32'd0
       && rsp_merges_done == 2'd0))
      else $error("error word carries a grant");

   a_none_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == KIND_NONE) |=> !rsp_valid)
      else $error("unknown kind produced a result");
endmodule

bind first_fit_region_allocator_unit ffra_checker u_ffra_checker (.*);

/* sim/first_fit_region_allocator_unit_tb.sv */
// self-checking testbench of the first-fit region allocator unit: directed and random words against a predictor
module first_fit_region_allocator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ffra_pkg::*;

   localparam int NDESC = 64;
   localparam int NIL = NDESC;
   localparam longint unsigned TOP_ADDR = 64'hFFFF_FFFF;

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] bytes;
      logic [31:0] addr;
   } req_word_type;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] addr;
      logic [31:0] len;
      logic [1:0]  merges;
   } grant_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_kind = KIND_ALLOC;
   logic [31:0] req_request_bytes = '0;
   logic [31:0] req_block_address = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_granted_address;
   logic [31:0] rsp_granted_length;
   logic [1:0]  rsp_merges_done;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_BASE;
   logic [31:0] csr_wdata = '0;

   req_word_type   pending_words[$];
   grant_word_type expected_grants[$];
   int             mismatches = 0;
   int             gap_left = 0;
   bit             no_gaps = 1'b0;

   // allocator state mirror
   logic [31:0]     shadow_base, shadow_len;
   longint unsigned seg_lo[NDESC];
   longint unsigned seg_hi[NDESC];
   int              seg_next[NDESC];
   int              head_free, head_used, head_spare;

   first_fit_region_allocator_unit u_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int locate_before(int head, longint unsigned key, output int after_idx);
      int p, c, steps;
      p = NIL;
      c = head;
      steps = 0;
      while (c < NIL && steps < NDESC && seg_lo[c] < key) begin
         p = c;
         c = seg_next[c];
         steps++;
      end
      after_idx = c;
      return p;
   endfunction

   function automatic void reload_region();
      longint unsigned hi;
      for (int i = 0; i < NDESC; i++) begin
         seg_lo[i] = 0;
         seg_hi[i] = 0;
         seg_next[i] = i + 1;
      end
      head_used = NIL;
      if (shadow_len == 0) begin
         head_free = NIL;
         head_spare = 0;
         return;
      end
      hi = 64'(shadow_base) + 64'(shadow_len) - 64'd1;
      if (hi > TOP_ADDR) hi = TOP_ADDR;
      seg_lo[0] = 64'(shadow_base);
      seg_hi[0] = hi;
      seg_next[0] = NIL;
      head_free = 0;
      head_spare = 1;
   endfunction

   function automatic grant_word_type predict_grant(req_word_type w);
      grant_word_type g;
      longint unsigned need;
      int prev, cur, steps, repl, nx, p, c, n, left;
      g = '{ST_OK, '0, '0, '0};
      need = 64'(w.bytes);
      if (w.kind == KIND_REINIT) begin
         reload_region();
         if (head_free < NIL) begin
            g.addr = 32'(seg_lo[0]);
            g.len = 32'(seg_hi[0] - seg_lo[0] + 1);
         end
      end else if (w.kind == KIND_ALLOC) begin
         if (need == 0) begin
            g.status = ST_ZERO_ARG;
         end else begin
            prev = NIL;
            cur = head_free;
            steps = 0;
            while (cur < NIL && steps < NDESC && need - 1 > seg_hi[cur] - seg_lo[cur]) begin
               prev = cur;
               cur = seg_next[cur];
               steps++;
            end
            if (cur >= NIL || steps >= NDESC) begin
               g.status = ST_NO_FIT;
            end else if (need - 1 < seg_hi[cur] - seg_lo[cur] && head_spare >= NIL) begin
               g.status = ST_NO_DESC;
            end else begin
               if (need - 1 < seg_hi[cur] - seg_lo[cur]) begin
                  repl = head_spare;
                  head_spare = seg_next[repl];
                  seg_lo[repl] = seg_lo[cur] + need;
                  seg_hi[repl] = seg_hi[cur];
                  seg_next[repl] = seg_next[cur];
                  seg_hi[cur] = seg_lo[cur] + need - 1;
               end else begin
                  repl = seg_next[cur];
               end
               if (prev < NIL) seg_next[prev] = repl;
               else head_free = repl;
               p = locate_before(head_used, seg_lo[cur], nx);
               if (p < NIL) seg_next[p] = cur;
               else head_used = cur;
               seg_next[cur] = nx;
               g.addr = 32'(seg_lo[cur]);
               g.len = 32'(need);
            end
         end
      end else if (w.kind == KIND_FREE) begin
         if (w.addr == 0) begin
            g.status = ST_ZERO_ARG;
         end else begin
            p = locate_before(head_used, 64'(w.addr), c);
            if (c >= NIL || seg_lo[c] != 64'(w.addr)) begin
               g.status = ST_NOT_FOUND;
            end else begin
               if (p < NIL) seg_next[p] = seg_next[c];
               else head_used = seg_next[c];
               g.addr = 32'(seg_lo[c]);
               g.len = 32'(seg_hi[c] - seg_lo[c] + 1);
               p = locate_before(head_free, seg_lo[c], n);
               if (p < NIL) seg_next[p] = c;
               else head_free = c;
               seg_next[c] = n;
               left = c;
               if (p < NIL && seg_hi[p] + 1 == seg_lo[c]) begin
                  seg_hi[p] = seg_hi[c];
                  seg_next[p] = n;
                  seg_next[c] = head_spare;
                  head_spare = c;
                  g.merges++;
                  left = p;
               end
               if (n < NIL && seg_hi[left] + 1 == seg_lo[n]) begin
                  seg_hi[left] = seg_hi[n];
                  seg_next[left] = seg_next[n];
                  seg_next[n] = head_spare;
                  head_spare = n;
                  g.merges++;
               end
            end
         end
      end
      return g;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 120);
   endfunction

   // driver
   always @(posedge clock) begin : drive_words
      req_word_type w;
      int g;
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (!(start && busy)) begin
         g = start ? pick_gap() : gap_left;
         if (g == 0 && pending_words.size() > 0) begin
            w = pending_words.pop_front();
            start <= 1'b1;
            req_kind <= w.kind;
            req_request_bytes <= w.bytes;
            req_block_address <= w.addr;
            gap_left <= 0;
         end else begin
            start <= 1'b0;
            gap_left <= (g > 0) ? g - 1 : 0;
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin : watch_words
      grant_word_type e;
      if (reset) begin
         shadow_base = RESET_BASE;
         shadow_len = RESET_LENGTH;
         reload_region();
         expected_grants.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_grants.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result word: status %0d addr %h len %h merges %0d",
                           rsp_status, rsp_granted_address, rsp_granted_length,
                           rsp_merges_done);
            end else begin
               e = expected_grants.pop_front();
               if (rsp_status !== e.status || rsp_granted_address !== e.addr ||
                   rsp_granted_length !== e.len || rsp_merges_done !== e.merges) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch at %0t: expected %0d/%h/%h/%0d got %0d/%h/%h/%0d",
                              $realtime, e.status, e.addr, e.len, e.merges, rsp_status,
                              rsp_granted_address, rsp_granted_length, rsp_merges_done);
               end
            end
         end
         if (start && !busy && req_kind != KIND_NONE)
            expected_grants.push_back(predict_grant('{req_kind, req_request_bytes,
                                                      req_block_address}));
         if (csr_we) begin
            if (csr_index == CSR_BASE) shadow_base = csr_wdata;
            else shadow_len = csr_wdata;
         end
      end
   end

   task automatic push_word(logic [1:0] kind, logic [31:0] bytes, logic [31:0] addr);
      pending_words.push_back('{kind, bytes, addr});
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || expected_grants.size() != 0 || start || busy)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] pick_used_addr();
      int c, k;
      c = head_used;
      k = $urandom_range(0, 7);
      while (k > 0 && c < NIL && seg_next[c] < NIL) begin
         c = seg_next[c];
         k--;
      end
      return (c < NIL) ? 32'(seg_lo[c]) : $urandom;
   endfunction

   function automatic logic [31:0] pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 2) return 0;
      if (r < 32) return $urandom_range(1, 16);
      if (r < 60) return $urandom_range(1, 4096);
      if (r < 75 && head_free < NIL) return 32'(seg_hi[head_free] - seg_lo[head_free] + 1);
      if (r < 88) return 32'd1 << $urandom_range(0, 31);
      return $urandom;
   endfunction

   task automatic random_phase(int count, int alloc_pct);
      int r, n;
      while (count > 0) begin
         n = $urandom_range(1, 10);
         no_gaps = ($urandom_range(0, 5) == 0);
         for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < alloc_pct) push_word(KIND_ALLOC, pick_size(), $urandom);
            else if (r < 92) push_word(KIND_FREE, $urandom,
                                       ($urandom_range(0, 9) < 8) ? pick_used_addr() :
                                       (($urandom_range(0, 3) == 0) ? 32'd0 : $urandom));
            else if (r < 96) push_word(KIND_REINIT, $urandom, $urandom);
            else push_word(KIND_NONE, $urandom, $urandom);
         end
         count -= n;
         wait_drained();
      end
   endtask

   initial begin
      logic [31:0] bases[7];
      logic [31:0] lens[7];
      bases = '{32'h0000_1000, 32'h0000_0000, 32'hFFFF_F000, 32'h0000_0000, 32'h0, 32'hFFFF_FFFF,
                32'h0};
      lens = '{32'h0001_0000, 32'h0000_0100, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h0};
      bases[6] = $urandom;
      lens[6] = $urandom;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      push_word(KIND_ALLOC, 32'd0, 32'd0);
      push_word(KIND_FREE, 32'hFFFF_FFFF, 32'd0);
      push_word(KIND_FREE, 32'd0, 32'h0001_2345);
      push_word(KIND_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_word(KIND_ALLOC, 32'hFFFF_FFFF, 32'd0);
      push_word(KIND_ALLOC, RESET_LENGTH, 32'd0);
      push_word(KIND_ALLOC, 32'd1, 32'd0);
      push_word(KIND_FREE, 32'd0, RESET_BASE);
      push_word(KIND_ALLOC, 32'h100, 32'd0);
      push_word(KIND_ALLOC, 32'h100, 32'd0);
      push_word(KIND_ALLOC, 32'h100, 32'd0);
      push_word(KIND_FREE, 32'd0, RESET_BASE);
      push_word(KIND_FREE, 32'd0, RESET_BASE + 32'h200);
      push_word(KIND_FREE, 32'd0, RESET_BASE + 32'h100);
      push_word(KIND_ALLOC, 32'h8000_0000, 32'd0);
      push_word(KIND_ALLOC, 32'h000F_FFFF, 32'd0);
      push_word(KIND_ALLOC, 32'h1, 32'd0);
      push_word(KIND_FREE, 32'd0, RESET_BASE);
      push_word(KIND_REINIT, 32'd0, 32'd0);
      wait_drained();

      // allocation-heavy random words that can run out of descriptors
      random_phase(90, 80);
      for (int s = 0; s < 7; s++) begin
         write_csr(CSR_BASE, bases[s]);
         write_csr(CSR_LENGTH, lens[s]);
         push_word(KIND_REINIT, 32'd0, 32'd0);
         random_phase(70, (s % 2) ? 60 : 45);
      end

      wait_drained();
      if (mismatches == 0 && expected_grants.size() == 0)
         $display("PASS first_fit_region_allocator_unit");
      else
         $display("FAIL first_fit_region_allocator_unit");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAIL first_fit_region_allocator_unit");
      $finish;
   end

endmodule
